/* rtl/spr_pkg.sv */
// Package for the servo position reply parser.
// Holds the reply header codes, status codes, register indexes and reset values.
// No dependencies.
package spr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 9;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0]  HDR_BYTE     = 8'h55;
  localparam logic [BYTE_W-1:0]  REPLY_LEN    = 8'd5;
  localparam logic [BYTE_W-1:0]  POS_READ_CMD = 8'd28;
  localparam logic [INDEX_W-1:0] INDEX_MAX    = 9'd511;
  localparam logic [INDEX_W-1:0] HDR_LAST_IDX = 9'd4;

  localparam logic [BYTE_W-1:0] SERVO_ID_RESET     = 8'd1;
  localparam logic [BYTE_W-1:0] SEARCH_LIMIT_RESET = 8'd30;

  localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_HEADER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHKSUM = 2'd2;

endpackage

/* rtl/servo_position_reply_parser.sv */
// Servo position reply parser: one received byte per transfer, one result per buffer.
// Latency: a result is valid in the cycle after the transfer of the byte that ends it.
// One byte per cycle while in_ready holds; the per-byte state update is the only loop.
// A byte is taken whenever the result register is empty or being emptied.
// Reset (rst, synchronous) clears the parser and loads servo_id 1 and search_limit 30;
// the parser then ignores bytes until one arrives with start_req set.
module servo_position_reply_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spr_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                             start_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spr_pkg::POS_W-1:0]        position,
  output logic [spr_pkg::STATUS_W-1:0]     status
);

  logic [spr_pkg::BYTE_W-1:0]    servo_id;
  logic [spr_pkg::BYTE_W-1:0]    search_limit;

  logic [4*spr_pkg::BYTE_W-1:0]  recent_bytes, recent_bytes_next;
  logic [spr_pkg::INDEX_W-1:0]   byte_index, byte_index_next;
  logic                          locked, locked_next;
  logic [1:0]                    payload_count, payload_count_next;
  logic [spr_pkg::POS_W-1:0]     position_hold, position_hold_next;
  logic [spr_pkg::BYTE_W-1:0]    running_sum, running_sum_next;
  logic                          finished, finished_next;

  logic                          emit;
  logic [spr_pkg::POS_W-1:0]     emit_position;
  logic [spr_pkg::STATUS_W-1:0]  emit_status;

  logic                          accept;
  logic                          hit;
  logic [spr_pkg::BYTE_W-1:0]    limit;
  logic [spr_pkg::INDEX_W-1:0]   idx;
  logic [spr_pkg::BYTE_W-1:0]    sum_b;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign limit    = (search_limit == '0) ? spr_pkg::BYTE_W'(1) : search_limit;

  always_comb begin
    recent_bytes_next  = start_req ? '0 : recent_bytes;
    idx                = start_req ? '0 : byte_index;
    locked_next        = start_req ? 1'b0 : locked;
    payload_count_next = start_req ? 2'd0 : payload_count;
    position_hold_next = start_req ? '0 : position_hold;
    running_sum_next   = start_req ? '0 : running_sum;
    finished_next      = start_req ? 1'b0 : finished;
    byte_index_next    = idx;
    emit               = 1'b0;
    emit_position      = '0;
    emit_status        = spr_pkg::STATUS_OK;
    sum_b              = running_sum_next + rx_byte;
    hit = (recent_bytes_next[31:24] == spr_pkg::HDR_BYTE) &&
          (recent_bytes_next[23:16] == spr_pkg::HDR_BYTE) &&
          (recent_bytes_next[15:8] == servo_id) &&
          (recent_bytes_next[7:0] == spr_pkg::REPLY_LEN) &&
          (rx_byte == spr_pkg::POS_READ_CMD);
    if (!finished_next) begin
      if (idx < spr_pkg::INDEX_MAX) begin
        byte_index_next = idx + spr_pkg::INDEX_W'(1);
      end
      if (locked_next) begin
        unique case (payload_count_next)
          2'd0: begin
            position_hold_next = {8'd0, rx_byte};
            running_sum_next   = sum_b;
            payload_count_next = 2'd1;
          end
          2'd1: begin
            position_hold_next = {rx_byte, position_hold_next[7:0]};
            running_sum_next   = sum_b;
            payload_count_next = 2'd2;
          end
          default: begin
            emit          = 1'b1;
            finished_next = 1'b1;
            locked_next   = 1'b0;
            if (~running_sum_next == rx_byte) begin
              emit_position = position_hold_next;
              emit_status   = spr_pkg::STATUS_OK;
            end else begin
              emit_status = spr_pkg::STATUS_BAD_CHKSUM;
            end
          end
        endcase
      end else if (idx >= spr_pkg::HDR_LAST_IDX && hit) begin
        locked_next        = 1'b1;
        payload_count_next = 2'd0;
        position_hold_next = '0;
        running_sum_next   = servo_id + spr_pkg::REPLY_LEN + spr_pkg::POS_READ_CMD;
      end else if (idx >= spr_pkg::HDR_LAST_IDX &&
                   (idx - spr_pkg::INDEX_W'(3)) >= {1'b0, limit}) begin
        emit          = 1'b1;
        emit_status   = spr_pkg::STATUS_NO_HEADER;
        finished_next = 1'b1;
        locked_next   = 1'b0;
      end else begin
        recent_bytes_next = {recent_bytes_next[23:0], rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id      <= spr_pkg::SERVO_ID_RESET;
      search_limit  <= spr_pkg::SEARCH_LIMIT_RESET;
      recent_bytes  <= '0;
      byte_index    <= '0;
      locked        <= 1'b0;
      payload_count <= 2'd0;
      position_hold <= '0;
      running_sum   <= '0;
      finished      <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          spr_pkg::REG_SERVO_ID:     servo_id <= cfg_data;
          spr_pkg::REG_SEARCH_LIMIT: search_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        recent_bytes  <= recent_bytes_next;
        byte_index    <= byte_index_next;
        locked        <= locked_next;
        payload_count <= payload_count_next;
        position_hold <= position_hold_next;
        running_sum   <= running_sum_next;
        finished      <= finished_next;
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      position <= emit_position;
      status   <= emit_status;
    end
  end

  a_locked_not_finished : assert property (@(posedge clk) disable iff (rst)
    locked |-> !finished) else $error("parser locked after its result was given");

  a_payload_needs_lock : assert property (@(posedge clk) disable iff (rst)
    (payload_count != 2'd0) |-> (locked || finished))
    else $error("payload count set without header lock");

  a_lock_after_header : assert property (@(posedge clk) disable iff (rst)
    locked |-> (byte_index >= 9'd5)) else $error("header lock before five bytes");

  a_result_ends_buffer : assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (finished && !locked && out_valid))
    else $error("result transfer did not close the buffer");

  a_error_zero_position : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spr_pkg::STATUS_OK) |-> (position == '0))
    else $error("error result carries a position");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for servo_position_reply_parser: byte buffers go in, results are checked.
// Drives well-formed, truncated and noisy replies with random gaps and stalls against its own
// parser model; depends on spr_pkg and the parser RTL only.
module testbench;

  typedef struct {
    logic [spr_pkg::BYTE_W-1:0] value;
    logic                       opens;
    int unsigned                idle_cycles;
  } rx_item_t;

  typedef struct {
    logic [spr_pkg::POS_W-1:0]    position;
    logic [spr_pkg::STATUS_W-1:0] status;
  } reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write_en = 1'b0;
  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index = spr_pkg::REG_SERVO_ID;
  logic [spr_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [spr_pkg::BYTE_W-1:0]    rx_byte = '0;
  logic                          start_req = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [spr_pkg::POS_W-1:0]     position;
  logic [spr_pkg::STATUS_W-1:0]  status;

  rx_item_t                   pending_bytes[$];
  reply_t                     expected_replies[$];
  logic [spr_pkg::BYTE_W-1:0] build[$];
  rx_item_t                   cur_item;
  reply_t                     want;
  bit                         presenting = 1'b0;
  bit                         in_xfer = 1'b0;
  bit                         out_xfer = 1'b0;
  bit                         calm = 1'b0;
  int unsigned                gap_count = 0;
  int unsigned                stall_left = 0;
  int unsigned                bytes_queued = 0;
  int unsigned                mismatch_count = 0;

  // Parser model state and its copy of the registers.
  logic [spr_pkg::BYTE_W-1:0]  id_reg = spr_pkg::SERVO_ID_RESET;
  logic [spr_pkg::BYTE_W-1:0]  limit_reg = spr_pkg::SEARCH_LIMIT_RESET;
  logic [31:0]                 tail_bytes = '0;
  logic [spr_pkg::INDEX_W-1:0] buf_index = '0;
  bit                          hdr_locked = 1'b0;
  logic [1:0]                  payload_seen = '0;
  logic [spr_pkg::POS_W-1:0]   pos_acc = '0;
  logic [spr_pkg::BYTE_W-1:0]  sum_acc = '0;
  bit                          buf_done = 1'b1;

  servo_position_reply_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .start_req    (start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .position     (position),
    .status       (status)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic post_reply(input logic [spr_pkg::POS_W-1:0] pos,
                            input logic [spr_pkg::STATUS_W-1:0] st);
    reply_t r;
    r.position = pos;
    r.status = st;
    expected_replies.push_back(r);
    buf_done = 1'b1;
    hdr_locked = 1'b0;
  endtask

  task automatic parse_byte(input logic [spr_pkg::BYTE_W-1:0] b, input logic opens);
    int unsigned idx;
    int unsigned tries;
    tries = (limit_reg == 0) ? 1 : limit_reg;
    if (opens) begin
      tail_bytes = '0;
      buf_index = '0;
      hdr_locked = 1'b0;
      payload_seen = '0;
      pos_acc = '0;
      sum_acc = '0;
      buf_done = 1'b0;
    end
    if (buf_done) return;
    idx = buf_index;
    if (buf_index != spr_pkg::INDEX_MAX) buf_index = buf_index + 1'b1;
    if (hdr_locked) begin
      case (payload_seen)
        2'd0: begin
          pos_acc = {8'h00, b};
          sum_acc = sum_acc + b;
          payload_seen = 2'd1;
        end
        2'd1: begin
          pos_acc[15:8] = b;
          sum_acc = sum_acc + b;
          payload_seen = 2'd2;
        end
        default: begin
          if (b == ~sum_acc) post_reply(pos_acc, spr_pkg::STATUS_OK);
          else post_reply('0, spr_pkg::STATUS_BAD_CHKSUM);
        end
      endcase
      return;
    end
    if (idx >= spr_pkg::HDR_LAST_IDX) begin
      if (tail_bytes == {spr_pkg::HDR_BYTE, spr_pkg::HDR_BYTE, id_reg, spr_pkg::REPLY_LEN} &&
          b == spr_pkg::POS_READ_CMD) begin
        hdr_locked = 1'b1;
        payload_seen = '0;
        pos_acc = '0;
        sum_acc = id_reg + spr_pkg::REPLY_LEN + spr_pkg::POS_READ_CMD;
        return;
      end
      if (idx - 3 >= tries) begin
        post_reply('0, spr_pkg::STATUS_NO_HEADER);
        return;
      end
    end
    tail_bytes = {tail_bytes[23:0], b};
  endtask

  // Transfer tracking and result checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_byte(rx_byte, start_req);
        in_xfer = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_xfer = 1'b1;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result: position %h status %0d",
                                    position, status));
        end else begin
          want = expected_replies.pop_front();
          if (position !== want.position)
            report_mismatch($sformatf("position %h, expected %h", position, want.position));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (in_xfer) begin
      in_xfer = 1'b0;
      presenting = 1'b0;
    end
    if (!presenting && !rst && pending_bytes.size() != 0) begin
      if (gap_count < pending_bytes[0].idle_cycles) begin
        gap_count++;
      end else begin
        cur_item = pending_bytes.pop_front();
        gap_count = 0;
        presenting = 1'b1;
        rx_byte <= cur_item.value;
        start_req <= cur_item.opens;
      end
    end
    in_valid <= presenting;
  end

  always @(negedge clk) begin
    if (out_xfer) begin
      out_xfer = 1'b0;
      stall_left = calm ? 0 : $urandom_range(0, 18);
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      if (out_valid) stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [spr_pkg::BYTE_W-1:0] v, input logic opens);
    rx_item_t it;
    it.value = v;
    it.opens = opens;
    it.idle_cycles = calm ? 0 : $urandom_range(0, 18);
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic flush_buffer();
    foreach (build[i]) push_byte(build[i], i == 0);
    build.delete();
  endtask

  function automatic logic [spr_pkg::BYTE_W-1:0] junk_byte();
    return ($urandom_range(0, 5) == 0) ? spr_pkg::HDR_BYTE : 8'($urandom);
  endfunction

  function automatic logic [spr_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_reply(input int unsigned lead, input logic [spr_pkg::POS_W-1:0] pos,
                           input bit spoil);
    logic [spr_pkg::BYTE_W-1:0] chk;
    repeat (lead) build.push_back(junk_byte());
    chk = ~(id_reg + spr_pkg::REPLY_LEN + spr_pkg::POS_READ_CMD + pos[7:0] + pos[15:8]);
    if (spoil) chk = chk ^ 8'($urandom_range(1, 255));
    build.push_back(spr_pkg::HDR_BYTE);
    build.push_back(spr_pkg::HDR_BYTE);
    build.push_back(id_reg);
    build.push_back(spr_pkg::REPLY_LEN);
    build.push_back(spr_pkg::POS_READ_CMD);
    build.push_back(pos[7:0]);
    build.push_back(pos[15:8]);
    build.push_back(chk);
  endtask

  task automatic write_reg(input logic [spr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spr_pkg::BYTE_W-1:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == spr_pkg::REG_SERVO_ID) id_reg = v;
    else limit_reg = v;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || presenting || expected_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase();
    logic [spr_pkg::BYTE_W-1:0] v;
    int unsigned lim;
    int unsigned near;
    int unsigned lead;
    int unsigned phase_start;
    int unsigned kind;
    int unsigned keep;
    case ($urandom_range(0, 5))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = spr_pkg::HDR_BYTE;
      3: v = spr_pkg::REPLY_LEN;
      default: v = 8'($urandom);
    endcase
    write_reg(spr_pkg::REG_SERVO_ID, v);
    case ($urandom_range(0, 6))
      0: v = 8'h00;
      1: v = 8'h01;
      2: v = 8'hFF;
      3: v = 8'h02;
      default: v = 8'($urandom_range(3, 40));
    endcase
    write_reg(spr_pkg::REG_SEARCH_LIMIT, v);
    lim = (limit_reg == 0) ? 1 : limit_reg;
    near = (lim - 1 < 8) ? lim - 1 : 8;
    phase_start = bytes_queued;
    while (bytes_queued - phase_start < 150) begin
      calm = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        case ($urandom_range(0, 9))
          7: lead = lim - 1;
          8: lead = lim;
          default: lead = $urandom_range(0, near);
        endcase
        add_reply(lead, pick_pos(), $urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) build.push_back(junk_byte());
        flush_buffer();
      end else if (kind < 78) begin
        repeat ($urandom_range(1, ((lim < 20) ? lim : 20) + 6)) build.push_back(junk_byte());
        flush_buffer();
      end else if (kind < 90) begin
        lead = $urandom_range(0, near);
        add_reply(lead, pick_pos(), 1'b0);
        keep = lead + $urandom_range(1, 7);
        while (build.size() > keep) build.delete(build.size() - 1);
        flush_buffer();
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    calm = 1'b0;
    add_reply(0, pick_pos(), 1'b0);
    flush_buffer();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_byte(spr_pkg::HDR_BYTE, 1'b0);
    push_byte(8'h00, 1'b0);
    add_reply(0, 16'hFFFF, 1'b0);
    build.push_back(8'hA5);
    flush_buffer();
    build.push_back(spr_pkg::HDR_BYTE);
    build.push_back(spr_pkg::HDR_BYTE);
    build.push_back(id_reg);
    flush_buffer();
    add_reply(1, 16'h0000, 1'b1);
    flush_buffer();
    drain();

    write_reg(spr_pkg::REG_SERVO_ID, 8'hFF);
    write_reg(spr_pkg::REG_SEARCH_LIMIT, 8'h00);
    build.push_back(8'h12);
    build.push_back(8'h34);
    build.push_back(8'h56);
    build.push_back(8'h78);
    build.push_back(8'h9A);
    flush_buffer();
    add_reply(0, 16'h8001, 1'b0);
    flush_buffer();
    drain();

    while (bytes_queued < 2000) random_phase();

    drain();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* servo_position_reply_parser.f */
rtl/spr_pkg.sv
rtl/servo_position_reply_parser.sv
test/testbench.sv
